### sv/wrbmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbmp_pkg
// Shared types and constants for the walk reachability block.
// ----------------------------------------------------------------------------
package wrbmp_pkg;
  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] first_vertex;
    logic [4:0] second_vertex;
    logic [7:0] walk_length;
  } in_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic       found;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_STEP = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic emit_last;
  } status_t;
endpackage

### sv/wrbmp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbmp_ctrl
// Sequencer: decode commands, run the product steps, then emit results.
// ----------------------------------------------------------------------------
module wrbmp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  wrbmp_pkg::in_t   in_data,
  input  wrbmp_pkg::status_t status,
  output logic             busy,
  output wrbmp_pkg::cmd_t  cmd
);
  import wrbmp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op_t'(in_data.operation))
            OP_CLEAR: cmd.clr = 1'b1;
            OP_ADD:   cmd.add = 1'b1;
            OP_QUERY: begin
              cmd.load  = 1'b1;
              state_nxt = (in_data.walk_length >= 8'd2) ? ST_STEP : ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.step_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### sv/wrbmp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbmp_dp
// Adjacency store, reach vector, step counter and result encoder.
// ----------------------------------------------------------------------------
module wrbmp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  wrbmp_pkg::in_t     in_data,
  input  wrbmp_pkg::cmd_t    cmd,
  output wrbmp_pkg::status_t status,
  output logic               out_valid,
  output wrbmp_pkg::out_t    out_data
);
  import wrbmp_pkg::*;

  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vec_r, vec_nxt, mask, prod, low_bit;
  logic [7:0]              cnt_r;
  logic                    bad_r;
  logic [4:0]              vc_r;
  logic [4:0]              n;
  logic [MAX_VERTICES:0]   mask_w;
  logic [IDX_W-1:0]        low_idx;
  logic                    a_ok, b_ok;
  logic [IDX_W-1:0]        a_idx, b_idx;

  assign n      = (vc_r > 5'(MAX_VERTICES)) ? 5'(MAX_VERTICES) : vc_r;
  assign mask_w = ((MAX_VERTICES+1)'(1) << n) - (MAX_VERTICES+1)'(1);
  assign mask   = mask_w[MAX_VERTICES-1:0];
  assign a_ok   = (in_data.first_vertex != 5'd0) && (in_data.first_vertex <= n);
  assign b_ok   = (in_data.second_vertex != 5'd0) && (in_data.second_vertex <= n);
  assign a_idx  = IDX_W'(in_data.first_vertex - 5'd1);
  assign b_idx  = IDX_W'(in_data.second_vertex - 5'd1);

  // one boolean vector-matrix product
  always_comb begin
    prod = '0;
    for (int m = 0; m < MAX_VERTICES; m++) begin
      if (vec_r[m]) prod = prod | adj_r[m];
    end
  end

  // lowest set bit of the reach vector
  always_comb begin
    low_idx = '0;
    for (int i = MAX_VERTICES-1; i >= 0; i--) begin
      if (vec_r[i]) low_idx = IDX_W'(i);
    end
  end
  assign low_bit = MAX_VERTICES'(1) << low_idx;
  assign vec_nxt = vec_r & ~low_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 5'd16;
    end else if (cfg_we) begin
      vc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      for (int i = 0; i < MAX_VERTICES; i++) adj_r[i] <= '0;
    end else if (cmd.add && a_ok && b_ok) begin
      adj_r[a_idx][b_idx] <= 1'b1;
      adj_r[b_idx][a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bad_r <= !a_ok;
      vec_r <= adj_r[a_idx] & mask;
      cnt_r <= in_data.walk_length;
    end else if (cmd.step) begin
      vec_r <= prod & mask;
      cnt_r <= cnt_r - 8'd1;
    end else if (cmd.emit) begin
      vec_r <= vec_nxt;
    end
  end

  logic empty;
  assign empty            = bad_r || (vec_r == '0);
  assign status.step_last = (cnt_r <= 8'd2);
  assign status.emit_last = empty || (vec_nxt == '0);
  assign out_valid        = cmd.emit;
  assign out_data.vertex  = empty ? 5'd0 : 5'(low_idx) + 5'd1;
  assign out_data.found   = !empty;
  assign out_data.last    = status.emit_last;
endmodule

### sv/walk_reachability_by_matrix_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walk_reachability_by_matrix_power
// Boolean walk reachability: edge loads plus k-step reach-set queries.
// ----------------------------------------------------------------------------
// Clear and add complete without leaving idle; busy stays low afterward.
// A query loads the source row, then runs max(k-1,0) product steps, one per cycle,
// then emits R results (R = number of results, at least 1), one per cycle.
// Results appear one per cycle on out_valid; the receiver cannot stall.
// Synchronous reset clears the adjacency store and sets vertex_count to 16.
module walk_reachability_by_matrix_power (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  wrbmp_pkg::in_t   in_data,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  output logic             out_valid,
  output wrbmp_pkg::out_t  out_data
);
  import wrbmp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: accept a transfer when idle, then drive product and emit steps
  wrbmp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  // datapath: hold adjacency rows and iterate the source's reach vector
  wrbmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );
endmodule
